@@ design/vgnq_pkg.sv @@
// Package with shared types and constants for the volume gradient normal quantizer.
package vgnq_pkg;

    localparam int MAX_DIM    = 128;
    localparam int RING_DEPTH = 65536;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int DIM_W      = 8;
    localparam int POS_W      = $clog2(MAX_DIM);
    localparam int SLICE_W    = 2 * POS_W + 1;
    localparam int CNT_W      = 22;
    localparam int VOX_W      = 8;
    localparam int DIFF_W     = VOX_W + 2;
    localparam int MAG_W      = VOX_W + 1;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int Q2_W       = SQ_W + 2;
    localparam int RHS_W      = SQ_W + 14;
    localparam int T_W        = 7;
    localparam int TSQ_W      = 2 * T_W;
    localparam int PROD_W     = TSQ_W + Q2_W;
    localparam int NUM_TAPS   = 7;
    localparam int QSCALE     = 127;
    localparam int QSCALE_SQ  = 16129;

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        REG_DIM_X = 2'd0,
        REG_DIM_Y = 2'd1,
        REG_DIM_Z = 2'd2,
        REG_NONE  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic             operation;
        logic [VOX_W-1:0] voxel_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       grad_x;
        logic [7:0]       grad_y;
        logic [7:0]       grad_z;
        logic [VOX_W-1:0] center_value;
        logic             last;
    } t_out_item;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (d > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

@@ design/vgnq_ram.sv @@
// Generic single-port synchronous RAM with registered read.
module vgnq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/volume_gradient_normal_quantizer.sv @@
// Top level: slice-ring gradient and normal quantizer for a raster-order 8-bit volume.
// A pushed voxel is written to a single-port slice ring of 65536 bytes. Once a full slice
// beyond a voxel has arrived, or on a drain once the whole volume is in, the block emits
// that voxel: it reads seven ring entries (center and six neighbors) in ST_READ and ST_LAST,
// forms the weighted central differences, takes squares and their sum in ST_DIFF, ST_SQ and
// ST_SUM, then finds each quantized component by a 7-bit binary search in three parallel
// lanes, with a square phase and a compare phase per bit. The seven reads share one ring
// port. After a dimension write the input stalls while slice and volume sizes are recomputed.
module volume_gradient_normal_quantizer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  vgnq_pkg::t_in_item        i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output vgnq_pkg::t_out_item       o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [vgnq_pkg::DIM_W-1:0] i_cfg_data
);
    import vgnq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_LAST, ST_DIFF, ST_SQ, ST_SUM, ST_SEARCH, ST_DONE
    } t_state;

    t_state                r_state;
    logic [DIM_W-1:0]      r_dim_x, r_dim_y, r_dim_z;
    logic [DIM_W-1:0]      w_ex, w_ey, w_ez;
    logic [SLICE_W-1:0]    r_s;
    logic [CNT_W-1:0]      r_total;
    logic [1:0]            r_calc;
    logic [CNT_W-1:0]      r_samples, r_results;
    logic [POS_W-1:0]      r_out_x, r_out_y, r_out_z;
    logic [CNT_W-1:0]      r_k;
    logic [5:0]            r_ok;
    logic                  r_last;
    logic [2:0]            r_rd;
    logic [VOX_W-1:0]      r_v [NUM_TAPS];
    logic [MAG_W-1:0]      r_mag [3];
    logic                  r_neg [3];
    logic [SQ_W-1:0]       r_sq [3];
    logic [Q2_W-1:0]       r_q2;
    logic [RHS_W-1:0]      r_rhs [3];
    logic [T_W-1:0]        r_t [3];
    logic [TSQ_W-1:0]      r_csq [3];
    logic [2:0]            r_bit;
    logic                  r_phase;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  w_in_acc, w_cfg_acc, w_we, w_out_free;
    logic [RING_AW-1:0]    w_addr;
    logic [VOX_W-1:0]      w_rdata;
    logic [CNT_W-1:0]      w_samples_inc, w_step, w_tap;
    logic                  w_emit;
    logic [DIFF_W-1:0]     w_d [3];
    logic [7:0]            w_g [3];

    assign w_ex = eff_dim(r_dim_x);
    assign w_ey = eff_dim(r_dim_y);
    assign w_ez = eff_dim(r_dim_z);

    assign o_in_stall  = (r_state != ST_IDLE) || (r_calc != 2'd0);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_samples_inc = r_samples + CNT_W'(1);
    assign w_we = w_in_acc && (i_in_data.operation == OP_PUSH) && (r_samples < r_total);

    always_comb begin
        w_emit = 1'b0;
        if (i_in_data.operation == OP_PUSH) begin
            w_emit = (r_samples < r_total)
                  && ((w_samples_inc - r_results) > CNT_W'(r_s));
        end else begin
            w_emit = (r_samples >= r_total) && (r_results < r_total);
        end
    end

    always_comb begin
        w_step = CNT_W'(0);
        w_tap  = r_k;
        case (r_rd)
            3'd1, 3'd2: w_step = CNT_W'(1);
            3'd3, 3'd4: w_step = CNT_W'(w_ex);
            3'd5, 3'd6: w_step = CNT_W'(r_s);
            default:    w_step = CNT_W'(0);
        endcase
        case (r_rd)
            3'd1:    w_tap = r_ok[0] ? r_k - w_step : r_k;
            3'd2:    w_tap = r_ok[1] ? r_k + w_step : r_k;
            3'd3:    w_tap = r_ok[2] ? r_k - w_step : r_k;
            3'd4:    w_tap = r_ok[3] ? r_k + w_step : r_k;
            3'd5:    w_tap = r_ok[4] ? r_k - w_step : r_k;
            3'd6:    w_tap = r_ok[5] ? r_k + w_step : r_k;
            default: w_tap = r_k;
        endcase
    end

    assign w_addr = (r_state == ST_IDLE) ? r_samples[RING_AW-1:0] : w_tap[RING_AW-1:0];

    vgnq_ram #(
        .WIDTH(VOX_W),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(i_in_data.voxel_value),
        .o_rdata(w_rdata)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i] = DIFF_W'({1'b0, r_v[2*i+1]}) - DIFF_W'({1'b0, r_v[2*i+2]});
            if (r_ok[2*i] && r_ok[2*i+1]) begin
                w_d[i] = w_d[i];
            end else if (r_ok[2*i] || r_ok[2*i+1]) begin
                w_d[i] = w_d[i] <<< 1;
            end else begin
                w_d[i] = '0;
            end
            if (r_q2 == '0) begin
                w_g[i] = 8'(QSCALE);
            end else if (r_neg[i]) begin
                w_g[i] = 8'(QSCALE - 1) - 8'(r_t[i]);
            end else begin
                w_g[i] = 8'(QSCALE) + 8'(r_t[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_dim_x     <= DIM_W'(MAX_DIM);
            r_dim_y     <= DIM_W'(MAX_DIM);
            r_dim_z     <= DIM_W'(MAX_DIM);
            r_calc      <= 2'd2;
            r_samples   <= '0;
            r_results   <= '0;
            r_out_x     <= '0;
            r_out_y     <= '0;
            r_out_z     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_calc != 2'd0) begin
                r_calc <= r_calc - 2'd1;
            end
            r_s     <= SLICE_W'(w_ex) * SLICE_W'(w_ey);
            r_total <= CNT_W'(r_s) * CNT_W'(w_ez);
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_acc && (i_cfg_index != REG_NONE)) begin
                case (i_cfg_index)
                    REG_DIM_X: r_dim_x <= i_cfg_data;
                    REG_DIM_Y: r_dim_y <= i_cfg_data;
                    default:   r_dim_z <= i_cfg_data;
                endcase
                r_calc    <= 2'd2;
                r_samples <= '0;
                r_results <= '0;
                r_out_x   <= '0;
                r_out_y   <= '0;
                r_out_z   <= '0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (w_we) begin
                            r_samples <= w_samples_inc;
                        end
                        if (w_emit) begin
                            r_k     <= r_results;
                            r_ok[0] <= r_out_x != '0;
                            r_ok[1] <= (DIM_W'(r_out_x) + DIM_W'(1)) < w_ex;
                            r_ok[2] <= r_out_y != '0;
                            r_ok[3] <= (DIM_W'(r_out_y) + DIM_W'(1)) < w_ey;
                            r_ok[4] <= r_out_z != '0;
                            r_ok[5] <= (DIM_W'(r_out_z) + DIM_W'(1)) < w_ez;
                            r_last  <= (r_results + CNT_W'(1)) == r_total;
                            r_rd    <= '0;
                            r_state <= ST_READ;
                            if ((r_results + CNT_W'(1)) == r_total) begin
                                r_samples <= '0;
                                r_results <= '0;
                                r_out_x   <= '0;
                                r_out_y   <= '0;
                                r_out_z   <= '0;
                            end else begin
                                r_results <= r_results + CNT_W'(1);
                                if ((DIM_W'(r_out_x) + DIM_W'(1)) >= w_ex) begin
                                    r_out_x <= '0;
                                    if ((DIM_W'(r_out_y) + DIM_W'(1)) >= w_ey) begin
                                        r_out_y <= '0;
                                        r_out_z <= r_out_z + POS_W'(1);
                                    end else begin
                                        r_out_y <= r_out_y + POS_W'(1);
                                    end
                                end else begin
                                    r_out_x <= r_out_x + POS_W'(1);
                                end
                            end
                        end
                    end
                end
                ST_READ: begin
                    if (r_rd != 3'd0) begin
                        r_v[r_rd - 3'd1] <= w_rdata;
                    end
                    if (r_rd == 3'd6) begin
                        r_state <= ST_LAST;
                    end
                    r_rd <= r_rd + 3'd1;
                end
                ST_LAST: begin
                    r_v[NUM_TAPS-1] <= w_rdata;
                    r_state <= ST_DIFF;
                end
                ST_DIFF: begin
                    for (int i = 0; i < 3; i++) begin
                        r_neg[i] <= w_d[i][DIFF_W-1];
                        r_mag[i] <= w_d[i][DIFF_W-1] ? MAG_W'(-w_d[i]) : MAG_W'(w_d[i]);
                    end
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    for (int i = 0; i < 3; i++) begin
                        r_sq[i] <= SQ_W'(r_mag[i]) * SQ_W'(r_mag[i]);
                    end
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_q2 <= Q2_W'(r_sq[0]) + Q2_W'(r_sq[1]) + Q2_W'(r_sq[2]);
                    for (int i = 0; i < 3; i++) begin
                        r_rhs[i] <= RHS_W'(r_sq[i]) * RHS_W'(QSCALE_SQ);
                        r_t[i]   <= '0;
                    end
                    r_bit   <= 3'(T_W - 1);
                    r_phase <= 1'b0;
                    r_state <= ST_SEARCH;
                end
                ST_SEARCH: begin
                    for (int i = 0; i < 3; i++) begin
                        if (!r_phase) begin
                            r_csq[i] <= TSQ_W'(r_t[i] | (T_W'(1) << r_bit))
                                      * TSQ_W'(r_t[i] | (T_W'(1) << r_bit));
                        end else if (r_neg[i]
                                ? (PROD_W'(r_csq[i]) * PROD_W'(r_q2) <  PROD_W'(r_rhs[i]))
                                : (PROD_W'(r_csq[i]) * PROD_W'(r_q2) <= PROD_W'(r_rhs[i]))) begin
                            r_t[i] <= r_t[i] | (T_W'(1) << r_bit);
                        end
                    end
                    r_phase <= !r_phase;
                    if (r_phase) begin
                        r_bit <= r_bit - 3'd1;
                        if (r_bit == 3'd0) begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out.grad_x       <= w_g[0];
                        r_out.grad_y       <= w_g[1];
                        r_out.grad_z       <= w_g[2];
                        r_out.center_value <= r_v[0];
                        r_out.last         <= r_last;
                        r_out_valid        <= 1'b1;
                        r_state            <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_ring_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == ST_IDLE))
        else $error("ring write outside idle");

    a_results_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_calc == 2'd0) |-> (r_results <= r_samples))
        else $error("results ahead of samples");

    a_grad_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.grad_x <= 8'd254 && o_out_data.grad_y <= 8'd254
                         && o_out_data.grad_z <= 8'd254))
        else $error("gradient code out of range");
endmodule

@@ tb/tb_volume_gradient_normal_quantizer.sv @@
// Testbench for volume_gradient_normal_quantizer: directed and random volumes, scoreboard check.
module tb_volume_gradient_normal_quantizer;
    import vgnq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 6000;
    localparam int DRAIN_WAIT  = 60;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [DIM_W-1:0] i_cfg_data;

    volume_gradient_normal_quantizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // golden state
    logic [7:0]  vol_ring [RING_DEPTH];
    int unsigned vox_stored;
    int unsigned normals_done;
    int unsigned pos_x, pos_y, pos_z;
    logic [7:0]  dim_reg [3];
    t_out_item   exp_normals [$];

    int  errors;
    int  counted_items;
    bit  calm;
    int  hold_cycles;
    int  quiet_cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int unsigned clamp_dim(logic [7:0] d);
        if (d == 0) return 1;
        if (d > MAX_DIM) return MAX_DIM;
        return d;
    endfunction

    function automatic int ring_at(int unsigned idx);
        return int'(vol_ring[idx % RING_DEPTH]);
    endfunction

    function automatic int weighted_diff(bit lo_ok, bit hi_ok, int unsigned k, int unsigned step);
        int lo;
        int hi;
        lo = ring_at(lo_ok ? k - step : k);
        hi = ring_at(hi_ok ? k + step : k);
        if (lo_ok && hi_ok) return lo - hi;
        if (lo_ok || hi_ok) return 2 * (lo - hi);
        return 0;
    endfunction

    function automatic logic [7:0] quant_component(int a, longint unsigned q2);
        longint unsigned mag;
        longint unsigned rhs;
        longint unsigned lhs;
        bit ok;
        mag = (a < 0) ? longint'(-a) : longint'(a);
        rhs = mag * mag * QSCALE_SQ;
        if (q2 == 0) return 8'(QSCALE);
        for (int t = 127; t > -127; t--) begin
            lhs = longint'(t * t) * q2;
            if (t > 0) ok = (a >= 0) && (lhs <= rhs);
            else ok = (a >= 0) || (lhs >= rhs);
            if (ok) return 8'(t + 127);
        end
        return 8'd0;
    endfunction

    function automatic void restart_stream();
        vox_stored   = 0;
        normals_done = 0;
        pos_x = 0;
        pos_y = 0;
        pos_z = 0;
    endfunction

    function automatic void emit_normal(int unsigned ex, int unsigned ey, int unsigned ez);
        int unsigned s;
        int unsigned k;
        int ax, ay, az;
        longint unsigned q2;
        t_out_item r;
        s = ex * ey;
        k = normals_done;
        ax = weighted_diff(pos_x > 0, pos_x + 1 < ex, k, 1);
        ay = weighted_diff(pos_y > 0, pos_y + 1 < ey, k, ex);
        az = weighted_diff(pos_z > 0, pos_z + 1 < ez, k, s);
        q2 = longint'(ax * ax) + longint'(ay * ay) + longint'(az * az);
        r.grad_x = quant_component(ax, q2);
        r.grad_y = quant_component(ay, q2);
        r.grad_z = quant_component(az, q2);
        r.center_value = vol_ring[k % RING_DEPTH];
        r.last = (k + 1 == s * ez);
        exp_normals = {exp_normals, r};
        if (r.last) begin
            restart_stream();
            return;
        end
        normals_done++;
        pos_x++;
        if (pos_x >= ex) begin
            pos_x = 0;
            pos_y++;
            if (pos_y >= ey) begin
                pos_y = 0;
                pos_z++;
            end
        end
    endfunction

    // returns 1 when the item stored a voxel or produced a result
    function automatic bit predict_gradient(t_in_item it);
        int unsigned ex, ey, ez, s, total;
        ex = clamp_dim(dim_reg[0]);
        ey = clamp_dim(dim_reg[1]);
        ez = clamp_dim(dim_reg[2]);
        s = ex * ey;
        total = s * ez;
        if (t_op'(it.operation) == OP_PUSH) begin
            if (vox_stored >= total) return 0;
            vol_ring[vox_stored % RING_DEPTH] = it.voxel_value;
            vox_stored++;
            if (vox_stored - normals_done > s) emit_normal(ex, ey, ez);
            return 1;
        end
        if (vox_stored < total || normals_done >= total) return 0;
        emit_normal(ex, ey, ez);
        return 1;
    endfunction

    function automatic int unsigned volume_size();
        return clamp_dim(dim_reg[0]) * clamp_dim(dim_reg[1]) * clamp_dim(dim_reg[2]);
    endfunction

    task automatic send_item(t_op op, logic [7:0] val);
        t_in_item it;
        bit acc;
        it.operation = op;
        it.voxel_value = val;
        if (!calm && $urandom_range(99) < 31) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do begin
            @(negedge i_clk);
            acc = !o_in_stall;
            @(posedge i_clk);
        end while (!acc);
        if (predict_gradient(it)) counted_items++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        wait (exp_normals.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_dim(t_reg_idx idx, logic [7:0] val);
        bit acc;
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(negedge i_clk);
            acc = o_cfg_ready;
            @(posedge i_clk);
        end while (!acc);
        i_cfg_valid <= 1'b0;
        dim_reg[idx] = val;
        restart_stream();
    endtask

    task automatic set_dims(logic [7:0] x, logic [7:0] y, logic [7:0] z);
        write_dim(REG_DIM_X, x);
        write_dim(REG_DIM_Y, y);
        write_dim(REG_DIM_Z, z);
    endtask

    task automatic finish_volume();
        while (vox_stored != 0) send_item(OP_DRAIN, 8'($urandom));
    endtask

    task automatic test_default_dims();
        send_item(OP_PUSH, 8'd0);
        send_item(OP_PUSH, 8'd255);
        send_item(OP_DRAIN, 8'd0);
        send_item(OP_PUSH, 8'd128);
        send_item(OP_DRAIN, 8'd255);
    endtask

    task automatic test_borders();
        logic [7:0] vals [12] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd1, 8'd254,
                                  8'd128, 8'd127, 8'd0, 8'd0, 8'd255, 8'd255};
        set_dims(8'd3, 8'd2, 8'd2);
        send_item(OP_DRAIN, 8'd0);
        foreach (vals[i]) send_item(OP_PUSH, vals[i]);
        send_item(OP_PUSH, 8'd77);
        finish_volume();
        set_dims(8'd2, 8'd2, 8'd2);
        repeat (8) send_item(OP_PUSH, 8'd90);
        finish_volume();
    endtask

    task automatic test_dim_extremes();
        set_dims(8'd0, 8'd200, 8'd1);
        for (int i = 0; i < 128; i++) send_item(OP_PUSH, 8'($urandom));
        finish_volume();
        set_dims(8'd128, 8'd1, 8'd2);
        for (int i = 0; i < 256; i++) send_item(OP_PUSH, 8'(i));
        finish_volume();
        set_dims(8'd1, 8'd1, 8'd1);
        send_item(OP_PUSH, 8'd200);
        send_item(OP_PUSH, 8'd3);
        finish_volume();
    endtask

    task automatic test_restart();
        set_dims(8'd4, 8'd3, 8'd2);
        repeat (16) send_item(OP_PUSH, 8'($urandom));
        write_dim(REG_DIM_Z, 8'd2);
        repeat (24) send_item(OP_PUSH, 8'($urandom));
        finish_volume();
    endtask

    task automatic test_backpressure();
        set_dims(8'd5, 8'd4, 8'd3);
        hold_cycles = 400;
        repeat (60) send_item(OP_PUSH, 8'($urandom));
        finish_volume();
    endtask

    task automatic test_random_volumes();
        int unsigned total;
        int unsigned stop_at;
        int vol;
        logic [7:0] d [3];
        logic [7:0] v;
        vol = 0;
        while (counted_items < 1850) begin
            vol++;
            for (int a = 0; a < 3; a++) d[a] = 8'($urandom_range(1, 6));
            case ($urandom_range(9))
                0: d[$urandom_range(2)] = 8'($urandom_range(100, 128));
                1: d[$urandom_range(2)] = ($urandom_range(1) != 0)
                                          ? 8'd0 : 8'($urandom_range(129, 255));
                default: ;
            endcase
            set_dims(d[0], d[1], d[2]);
            calm = (vol == 6);
            total = volume_size();
            stop_at = ($urandom_range(9) == 0) ? $urandom_range(0, total) : total;
            v = 8'($urandom);
            for (int i = 0; i < stop_at; i++) begin
                if ($urandom_range(19) == 0) send_item(OP_DRAIN, 8'($urandom));
                case ($urandom_range(3))
                    0: v = 8'($urandom);
                    1: v = ($urandom_range(1) != 0) ? 8'd0 : 8'd255;
                    default: v = v + 8'($urandom_range(0, 6)) - 8'd3;
                endcase
                send_item(OP_PUSH, v);
            end
            if (stop_at == total) begin
                if ($urandom_range(9) == 0) send_item(OP_PUSH, 8'($urandom));
                finish_volume();
            end
            calm = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 31);
        end
    end

    always @(negedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("volume_gradient_normal_quantizer verification failed");
                $finish;
            end
            if (o_out_valid && !i_out_stall) begin
                if (exp_normals.size() == 0) begin
                    $display("%0t: unexpected result %p", $realtime, o_out_data);
                    errors++;
                end else begin
                    want = exp_normals.pop_front();
                    if (want.grad_x !== o_out_data.grad_x)
                        $display("%0t: grad_x expected %0d actual %0d", $realtime,
                                 want.grad_x, o_out_data.grad_x);
                    if (want.grad_y !== o_out_data.grad_y)
                        $display("%0t: grad_y expected %0d actual %0d", $realtime,
                                 want.grad_y, o_out_data.grad_y);
                    if (want.grad_z !== o_out_data.grad_z)
                        $display("%0t: grad_z expected %0d actual %0d", $realtime,
                                 want.grad_z, o_out_data.grad_z);
                    if (want.center_value !== o_out_data.center_value)
                        $display("%0t: center_value expected %0d actual %0d", $realtime,
                                 want.center_value, o_out_data.center_value);
                    if (want.last !== o_out_data.last)
                        $display("%0t: last expected %0d actual %0d", $realtime,
                                 want.last, o_out_data.last);
                    if (want !== o_out_data) errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_DIM_X;
        i_cfg_data  = '0;
        errors = 0;
        counted_items = 0;
        calm = 1'b0;
        hold_cycles = 0;
        quiet_cycles = 0;
        dim_reg[0] = 8'(MAX_DIM);
        dim_reg[1] = 8'(MAX_DIM);
        dim_reg[2] = 8'(MAX_DIM);
        restart_stream();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_dims();
        test_borders();
        test_dim_extremes();
        test_restart();
        test_backpressure();
        test_random_volumes();
        settle();
        if (errors == 0) begin
            $display("volume_gradient_normal_quantizer verification clean");
        end else begin
            $display("volume_gradient_normal_quantizer verification failed");
        end
        $finish;
    end

endmodule
